[src/dffir_pkg.sv]
// ---------------------------------------------------------------------------
// dffir_pkg
// Shared constants, codes and control/status types for the direct-form FIR
// filter.
// ---------------------------------------------------------------------------
`default_nettype none

package dffir_pkg;

   // default configuration of the block
   localparam int DEF_MAX_TAPS     = 256;
   localparam int DEF_SAMPLE_WIDTH = 16;

   // fixed field widths
   localparam int TAP_COUNT_WIDTH = 9;
   localparam int TAP_INDEX_WIDTH = 8;
   localparam int COEF_WIDTH      = 16;
   localparam int FRAC_BITS       = 15;

   // request action codes
   localparam logic ACT_LOAD   = 1'b0;
   localparam logic ACT_SAMPLE = 1'b1;

   // controller to datapath commands
   typedef struct packed {
      logic load;      // write one coefficient
      logic start;     // latch sample and tap count, start position reduction
      logic clear;     // write one zero entry of the delay line
      logic mod_step;  // one remainder step of the position reduction
      logic write;     // store sample, set up tap loop, step write position
      logic issue;     // read one coefficient/sample pair
      logic finish;    // scale, saturate and load the output register
   } dffir_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic clr_last;
      logic mod_last;
      logic issue_last;
      logic pipe_empty;
      logic out_free;
   } dffir_stat_type;

endpackage

`default_nettype wire

[src/dffir_req_if.sv]
// ---------------------------------------------------------------------------
// dffir_req_if
// Request channel: coefficient loads and input samples.
// ---------------------------------------------------------------------------
`default_nettype none

interface dffir_req_if
   import dffir_pkg::*;
#(
   parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
);
   logic                              valid;
   logic                              ready;
   logic                              action;
   logic [TAP_INDEX_WIDTH-1:0]        tap_index;
   logic signed [SAMPLE_WIDTH-1:0]    value;

   modport source (output valid, output action, output tap_index, output value,
                   input ready);
   modport sink   (input valid, input action, input tap_index, input value,
                   output ready);
endinterface

`default_nettype wire

[src/dffir_rsp_if.sv]
// ---------------------------------------------------------------------------
// dffir_rsp_if
// Response channel: filtered samples.
// ---------------------------------------------------------------------------
`default_nettype none

interface dffir_rsp_if
   import dffir_pkg::*;
#(
   parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
);
   logic                              valid;
   logic                              ready;
   logic signed [SAMPLE_WIDTH-1:0]    sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

[src/dffir_ram.sv]
// ---------------------------------------------------------------------------
// dffir_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module dffir_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

`default_nettype wire

[src/dffir_ctrl.sv]
// ---------------------------------------------------------------------------
// dffir_ctrl
// Sequencer: delay-line clear after reset, position reduction, tap loop,
// pipeline drain and result hand-off.
// ---------------------------------------------------------------------------
`default_nettype none

module dffir_ctrl
   import dffir_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   input  wire logic           req_action,
   input  wire dffir_stat_type stat,
   output dffir_cmd_type       cmd,
   output logic                req_ready
);
   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_MOD   = 3'd2;
   localparam logic [2:0] ST_WRITE = 3'd3;
   localparam logic [2:0] ST_MAC   = 3'd4;
   localparam logic [2:0] ST_DRAIN = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && req_action == ACT_LOAD) begin
               cmd.load = 1'b1;
            end
            if (req_valid && req_action == ACT_SAMPLE) begin
               cmd.start = 1'b1;
               state_in  = ST_MOD;
            end
         end
         ST_MOD: begin
            cmd.mod_step = 1'b1;
            if (stat.mod_last) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.write = 1'b1;
            state_in  = ST_MAC;
         end
         ST_MAC: begin
            cmd.issue = 1'b1;
            if (stat.issue_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (stat.pipe_empty && stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

`default_nettype wire

[src/dffir_dp.sv]
// ---------------------------------------------------------------------------
// dffir_dp
// Datapath: tap count register, coefficient and delay-line RAMs, restoring
// remainder unit for the write position, multiply-accumulate pipeline and
// output register with scaling and saturation.
// ---------------------------------------------------------------------------
`default_nettype none

module dffir_dp
   import dffir_pkg::*;
#(
   parameter int MAX_TAPS     = DEF_MAX_TAPS,
   parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire dffir_cmd_type                  cmd,
   output dffir_stat_type                      stat,
   input  wire logic                           csr_we,
   input  wire logic [TAP_COUNT_WIDTH-1:0]     csr_wdata,
   input  wire logic [TAP_INDEX_WIDTH-1:0]     req_tap_index,
   input  wire logic signed [SAMPLE_WIDTH-1:0] req_value,
   input  wire logic                           rsp_ready,
   output logic                                rsp_valid,
   output logic signed [SAMPLE_WIDTH-1:0]      rsp_sample_out
);
   localparam int AW   = $clog2(MAX_TAPS);
   localparam int CW   = $clog2(MAX_TAPS + 1);
   localparam int NW   = $clog2(AW + 1);
   localparam int PW   = COEF_WIDTH + SAMPLE_WIDTH;
   localparam int ACCW = PW + AW;
   localparam int QW   = ACCW - FRAC_BITS;
   localparam int SW   = SAMPLE_WIDTH;

   // configuration and control registers
   logic [TAP_COUNT_WIDTH-1:0] tap_count_ff;
   logic [AW-1:0]              wp_ff, wp_in;
   logic [AW-1:0]              clr_ff;
   logic [CW-1:0]              len_ff;
   logic [AW-1:0]              lm1_ff;
   logic [AW-1:0]              div_ff;
   logic [CW-1:0]              rem_ff, rem_in;
   logic [NW-1:0]              cnt_ff;
   logic [AW-1:0]              j_ff, k_ff;
   logic                       rd_v_ff, prod_v_ff;
   logic                       rsp_valid_ff;

   // payload registers
   logic signed [SW-1:0]       sample_ff;
   logic signed [PW-1:0]       prod_ff, prod_in;
   logic signed [ACCW-1:0]     acc_ff;
   logic signed [SW-1:0]       rsp_data_ff, rsp_data_in;

   logic [CW-1:0]              eff_len;
   logic [CW:0]                trial;
   logic [AW-1:0]              pos;
   logic                       coef_we;
   logic                       dl_we;
   logic [AW-1:0]              dl_waddr;
   logic [SW-1:0]              dl_wdata;
   logic [COEF_WIDTH-1:0]      coef_rd;
   logic [SW-1:0]              smp_rd;
   logic [QW-1:0]              q;
   logic [QW-SW:0]             q_top;

   // effective tap count: zero means one, clamp to the store depth
   always_comb begin
      if (tap_count_ff == '0) begin
         eff_len = CW'(1);
      end else if (32'(tap_count_ff) > 32'(MAX_TAPS)) begin
         eff_len = CW'(MAX_TAPS);
      end else begin
         eff_len = CW'(tap_count_ff);
      end
   end

   // one restoring remainder step: write position mod tap count
   assign trial  = {rem_ff, div_ff[AW-1]};
   assign rem_in = (trial >= {1'b0, len_ff}) ? CW'(trial - {1'b0, len_ff}) : CW'(trial);
   assign pos    = AW'(rem_ff);
   assign wp_in  = (pos == '0) ? lm1_ff : pos - AW'(1);

   // tap count register
   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= TAP_COUNT_WIDTH'(1);
      end else if (csr_we) begin
         tap_count_ff <= csr_wdata;
      end
   end

   // control: clear sweep, remainder steps, tap loop, pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff     <= '0;
         clr_ff    <= '0;
         cnt_ff    <= '0;
         j_ff      <= '0;
         k_ff      <= '0;
         rd_v_ff   <= 1'b0;
         prod_v_ff <= 1'b0;
      end else begin
         rd_v_ff   <= cmd.issue;
         prod_v_ff <= rd_v_ff;
         if (cmd.clear) begin
            clr_ff <= clr_ff + AW'(1);
         end
         if (cmd.start) begin
            cnt_ff <= '0;
         end else if (cmd.mod_step) begin
            cnt_ff <= cnt_ff + NW'(1);
         end
         if (cmd.write) begin
            wp_ff <= wp_in;
            j_ff  <= '0;
            k_ff  <= pos;
         end else if (cmd.issue) begin
            j_ff <= j_ff + AW'(1);
            k_ff <= (k_ff == lm1_ff) ? '0 : k_ff + AW'(1);
         end
      end
   end

   // item setup and remainder datapath
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         sample_ff <= req_value;
         len_ff    <= eff_len;
         lm1_ff    <= AW'(eff_len - CW'(1));
         div_ff    <= wp_ff;
         rem_ff    <= '0;
      end else if (cmd.mod_step) begin
         div_ff <= div_ff << 1;
         rem_ff <= rem_in;
      end
   end

   // coefficient store, loads outside the store are dropped
   assign coef_we = cmd.load && (32'(req_tap_index) < 32'(MAX_TAPS));

   dffir_ram #(
      .WIDTH (COEF_WIDTH),
      .DEPTH (MAX_TAPS)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_we),
      .wr_addr (AW'(req_tap_index)),
      .wr_data (COEF_WIDTH'($unsigned(req_value))),
      .rd_addr (j_ff),
      .rd_data (coef_rd)
   );

   // delay line: zero sweep after reset, then one sample write per item
   assign dl_we    = cmd.clear || cmd.write;
   assign dl_waddr = cmd.clear ? clr_ff : pos;
   assign dl_wdata = cmd.clear ? '0 : sample_ff;

   dffir_ram #(
      .WIDTH (SW),
      .DEPTH (MAX_TAPS)
   ) u_delay_ram (
      .clock   (clock),
      .wr_en   (dl_we),
      .wr_addr (dl_waddr),
      .wr_data (dl_wdata),
      .rd_addr (k_ff),
      .rd_data (smp_rd)
   );

   // multiply, then accumulate
   assign prod_in = $signed(coef_rd) * $signed(smp_rd);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (cmd.write) begin
         acc_ff <= '0;
      end else if (prod_v_ff) begin
         acc_ff <= acc_ff + ACCW'(prod_ff);
      end
   end

   // floor shift by the fraction bits, saturate to the sample width
   assign q     = acc_ff[ACCW-1:FRAC_BITS];
   assign q_top = q[QW-1:SW-1];

   always_comb begin
      if ((&q_top) || !(|q_top)) begin
         rsp_data_in = q[SW-1:0];
      end else if (q[QW-1]) begin
         rsp_data_in = {1'b1, {(SW-1){1'b0}}};
      end else begin
         rsp_data_in = {1'b0, {(SW-1){1'b1}}};
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

   // status to the controller
   assign stat.clr_last   = (clr_ff == AW'(MAX_TAPS - 1));
   assign stat.mod_last   = (cnt_ff == NW'(AW - 1));
   assign stat.issue_last = (j_ff == lm1_ff);
   assign stat.pipe_empty = !rd_v_ff && !prod_v_ff;
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;
endmodule

`default_nettype wire

[src/direct_form_fir_filter.sv]
// ---------------------------------------------------------------------------
// direct_form_fir_filter
// Direct-form FIR filter with a circular delay line and one shared
// multiply-accumulate unit.
//
// Request channel (req_chan): action selects a coefficient load (tap_index,
// value in Q1.15) or an input sample push (value). Response channel
// (rsp_chan): one filtered sample per pushed sample, none per load.
// csr_we/csr_wdata write the tap count; write it only while the block is idle.
//
// A coefficient load is written as it is accepted and the block stays ready.
// A sample first reduces the write position modulo the tap count by
// restoring remainder steps, then stores the sample, then runs the taps
// through the shared multiplier and drains the read/multiply/accumulate
// pipeline. Each store has a single RAM read port, so the taps are read
// one by one. The result sits in an output register, so the next item is
// taken while it waits; a further sample stalls in its last step only
// while that register is still full.
// After reset the delay line is cleared one entry per cycle, all MAX_TAPS
// entries, with req_chan.ready low; tap count returns to one.
// ---------------------------------------------------------------------------
`default_nettype none

module direct_form_fir_filter
   import dffir_pkg::*;
#(
   parameter int MAX_TAPS     = DEF_MAX_TAPS,
   parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   dffir_req_if.sink                       req_chan,
   dffir_rsp_if.source                     rsp_chan,
   input  wire logic                       csr_we,
   input  wire logic [TAP_COUNT_WIDTH-1:0] csr_wdata
);
   dffir_cmd_type  cmd;
   dffir_stat_type stat;
   logic           req_ready;

   // sequencer
   dffir_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_action (req_chan.action),
      .stat       (stat),
      .cmd        (cmd),
      .req_ready  (req_ready)
   );

   assign req_chan.ready = req_ready;

   // storage and arithmetic
   dffir_dp #(
      .MAX_TAPS     (MAX_TAPS),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .req_tap_index  (req_chan.tap_index),
      .req_value      (req_chan.value),
      .rsp_ready      (rsp_chan.ready),
      .rsp_valid      (rsp_chan.valid),
      .rsp_sample_out (rsp_chan.sample_out)
   );

`ifndef NO_ASSERTIONS
   // a result is never finished into a full output register
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("result finished while output register still full");

   // a finished transaction shows up on the response channel next cycle
   a_finish_out: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_chan.valid)
      else $error("finished result not presented");

   // no request is taken while the tap pipeline still holds data
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      !stat.pipe_empty |-> !req_chan.ready)
      else $error("request accepted during tap pipeline drain");
`endif
endmodule

`default_nettype wire

[bench/tb_direct_form_fir_filter.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_direct_form_fir_filter
// Self-checking bench for the direct-form FIR filter. A local bit-exact
// predictor mirrors the delay line, the coefficient store, the write position
// and the tap count. Every accepted sample pushes one predicted output, and
// each response transaction is checked against the oldest prediction. Both
// channels idle at random, and the response side holds off once for a long
// stretch so that the filter backs up onto its request channel.
// ---------------------------------------------------------------------------

module tb_direct_form_fir_filter
   import dffir_pkg::*;
();

   localparam int  MAX_TAPS      = DEF_MAX_TAPS;
   localparam int  SETTLE_CYCLES = 2 * MAX_TAPS + 32;
   localparam int  HOLD_CYCLES   = 1500;
   localparam int  PHASE_ITEMS   = 130;
   localparam int  LOAD_PCT      = 20;
   localparam int  BUSY_PCT      = 34;
   localparam longint CYCLE_LIMIT = 2_000_000;
   localparam longint SAT_HI = (longint'(1) <<< (DEF_SAMPLE_WIDTH - 1)) - 1;
   localparam longint SAT_LO = -SAT_HI - 1;

   typedef logic signed [DEF_SAMPLE_WIDTH-1:0] sample_type;
   typedef logic [TAP_COUNT_WIDTH-1:0]         taps_type;
   typedef logic [TAP_INDEX_WIDTH-1:0]         index_type;

   logic      clock = 1'b0;
   logic      reset;
   logic      csr_we;
   taps_type  csr_wdata;

   dffir_req_if #(.SAMPLE_WIDTH(DEF_SAMPLE_WIDTH)) req_chan ();
   dffir_rsp_if #(.SAMPLE_WIDTH(DEF_SAMPLE_WIDTH)) rsp_chan ();

   direct_form_fir_filter #(
      .MAX_TAPS     (MAX_TAPS),
      .SAMPLE_WIDTH (DEF_SAMPLE_WIDTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   sample_type  delay_q [MAX_TAPS];
   sample_type  coef_q  [MAX_TAPS];
   int unsigned write_pos_q;
   taps_type    tap_count_q;
   sample_type  expected_out_q [$];

   int     fail_count  = 0;
   int     idle_pct    = BUSY_PCT;
   int     stall_req   = 0;
   longint cycle_count = 0;

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // compute the filter output for one pushed sample and advance the state
   function automatic sample_type filter_sample(input sample_type x);
      int unsigned len;
      int unsigned pos;
      int unsigned k;
      int unsigned j;
      longint      acc;
      longint      q;
      if (tap_count_q == 0)
         len = 1;
      else if (tap_count_q > MAX_TAPS)
         len = MAX_TAPS;
      else
         len = tap_count_q;
      pos = write_pos_q % len;
      delay_q[pos] = x;
      acc = 0;
      k = pos;
      for (j = 0; j < len; j++) begin
         acc += longint'(coef_q[j]) * longint'(delay_q[k]);
         k = (k + 1 >= len) ? 0 : k + 1;
      end
      write_pos_q = (pos == 0) ? len - 1 : pos - 1;
      q = acc >>> FRAC_BITS;
      if (q > SAT_HI)
         q = SAT_HI;
      if (q < SAT_LO)
         q = SAT_LO;
      return sample_type'(q);
   endfunction

   // random value with extra weight on the extremes
   function automatic sample_type rand_value();
      sample_type v;
      case ($urandom_range(0, 9))
         0: v = sample_type'(SAT_HI);
         1: v = sample_type'(SAT_LO);
         2: v = '0;
         default: v = sample_type'($urandom);
      endcase
      return v;
   endfunction

   // offer one request transaction; random gaps drive noise with valid low
   task automatic send_item(input logic act, input index_type idx, input sample_type val);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_chan.valid     <= 1'b0;
         req_chan.action    <= 1'($urandom);
         req_chan.tap_index <= index_type'($urandom);
         req_chan.value     <= sample_type'($urandom);
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.action    <= act;
      req_chan.tap_index <= idx;
      req_chan.value     <= val;
      do @(posedge clock); while (!req_chan.ready);
      if (act == ACT_LOAD)
         coef_q[idx] = val;
      else
         expected_out_q.push_back(filter_sample(val));
   endtask

   // drop valid, wait out all outputs and any load still in flight
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      while (expected_out_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // retune the filter length while it is idle
   task automatic set_tap_count(input taps_type taps);
      drain_results();
      csr_wdata <= taps;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we    <= 1'b0;
      tap_count_q = taps;
      @(posedge clock);
   endtask

   // fill every coefficient so no tap length reads an unwritten entry
   task automatic test_coef_fill();
      int i;
      for (i = 0; i < MAX_TAPS; i++)
         send_item(ACT_LOAD, index_type'(i), rand_value());
   endtask

   // one tap at reset length: saturation at the top and floor rounding
   task automatic test_single_tap();
      send_item(ACT_LOAD, '0, sample_type'(SAT_LO));
      send_item(ACT_SAMPLE, '1, sample_type'(SAT_LO));
      send_item(ACT_SAMPLE, '0, sample_type'(SAT_HI));
      send_item(ACT_LOAD, '0, sample_type'(SAT_HI));
      send_item(ACT_SAMPLE, '1, sample_type'(SAT_LO));
      send_item(ACT_SAMPLE, '0, sample_type'(SAT_HI));
      send_item(ACT_SAMPLE, '0, '0);
      send_item(ACT_SAMPLE, '1, sample_type'(-1));
      send_item(ACT_SAMPLE, '0, sample_type'(1));
   endtask

   // zero taps, oversize taps, a lowered length with a stale write position
   task automatic test_tap_count_edges();
      int i;
      set_tap_count('0);
      send_item(ACT_SAMPLE, '0, sample_type'(SAT_HI));
      send_item(ACT_SAMPLE, '1, sample_type'(SAT_LO));
      set_tap_count('1);
      for (i = 0; i < 3; i++)
         send_item(ACT_SAMPLE, index_type'($urandom), rand_value());
      set_tap_count(taps_type'(3));
      for (i = 0; i < 3; i++)
         send_item(ACT_LOAD, index_type'(i), sample_type'(SAT_LO));
      for (i = 0; i < 3; i++)
         send_item(ACT_SAMPLE, '0, sample_type'(SAT_HI));
      set_tap_count(taps_type'(MAX_TAPS));
      send_item(ACT_SAMPLE, '0, sample_type'(SAT_HI));
      send_item(ACT_SAMPLE, '1, sample_type'(SAT_LO));
   endtask

   // random loads and samples over a range of filter lengths
   task automatic test_random_phases();
      taps_type lengths [10];
      int       p;
      int       i;
      lengths = '{taps_type'(2), taps_type'($urandom_range(1, 16)), taps_type'(MAX_TAPS),
                  taps_type'($urandom_range(1, 40)), '0, '1, taps_type'(5),
                  taps_type'(MAX_TAPS - 1), taps_type'($urandom_range(1, 8)),
                  taps_type'(1)};
      for (p = 0; p < 10; p++) begin
         set_tap_count(lengths[p]);
         // keep one phase free of gaps on both sides
         idle_pct = (p == 3) ? 0 : BUSY_PCT;
         for (i = 0; i < PHASE_ITEMS; i++) begin
            if ($urandom_range(0, 99) < LOAD_PCT)
               send_item(ACT_LOAD, index_type'($urandom), rand_value());
            else
               send_item(ACT_SAMPLE, index_type'($urandom), rand_value());
         end
      end
      idle_pct = BUSY_PCT;
   endtask

   // hold the response side off so results back up into the request side
   task automatic test_backpressure();
      int i;
      set_tap_count(taps_type'(4));
      idle_pct = 0;
      stall_req++;
      for (i = 0; i < 40; i++)
         send_item(ACT_SAMPLE, index_type'($urandom), rand_value());
      idle_pct = BUSY_PCT;
   endtask

   // drive the response ready, with one long hold-off on request
   initial begin
      int stall_seen;
      int stall_left;
      stall_seen = 0;
      stall_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_req != stall_seen) begin
            stall_seen = stall_req;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 99) >= idle_pct);
         end
      end
   end

   // check each response transaction against the oldest prediction
   initial begin
      sample_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            if (expected_out_q.size() == 0) begin
               $error("sample_out: expected none, got %0d", rsp_chan.sample_out);
               fail_count++;
            end else begin
               want = expected_out_q.pop_front();
               if (rsp_chan.sample_out !== want) begin
                  $error("sample_out: expected %0d, got %0d", want, rsp_chan.sample_out);
                  fail_count++;
               end
            end
         end
      end
   end

   // main sequence
   initial begin
      int i;
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_wdata          = '0;
      req_chan.valid     = 1'b0;
      req_chan.action    = ACT_LOAD;
      req_chan.tap_index = '0;
      req_chan.value     = '0;
      for (i = 0; i < MAX_TAPS; i++) begin
         delay_q[i] = '0;
         coef_q[i]  = '0;
      end
      write_pos_q = 0;
      tap_count_q = taps_type'(1);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_coef_fill();
      test_single_tap();
      test_tap_count_edges();
      test_random_phases();
      test_backpressure();
      drain_results();

      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
